@@ src/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define BHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define BHA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/bha_pkg.sv @@
package bha_pkg;

  localparam int unsigned SLOT_COUNT = 1024;
  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned WORD_COUNT = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned IDX_W      = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int unsigned BIT_W      = $clog2(WORD_BITS);
  localparam int unsigned WIDX_W     = $clog2(WORD_COUNT);
  localparam int unsigned GEN_W      = 8;
  localparam int unsigned CFG_AW     = 3;
  localparam int unsigned CFG_DW     = 32;

  localparam logic [GEN_W-1:0] GEN_WRAP      = 8'd255;
  localparam logic [GEN_W-1:0] GEN_FIRST     = 8'd1;
  localparam logic [CNT_W-1:0] MAX_ENT_RESET = CNT_W'(SLOT_COUNT);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_GET   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_BAD  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_ALLOC,
    ST_CHECK,
    ST_RESP
  } state_e;

  // register index, taken from paddr above the byte offset
  typedef enum logic {
    REG_MAX_ENTITIES = 1'b0
  } reg_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] handle_index;
    logic [GEN_W-1:0] generation;
    logic             is_live;
    status_e          status;
    logic [CNT_W-1:0] live_total;
  } rsp_t;

  typedef struct packed {
    logic                 we;
    logic [WIDX_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [WIDX_W-1:0]    raddr;
  } occ_req_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [GEN_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } gen_req_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] pos;
  } find_t;

  // lowest bit that is clear in word and set in mask
  function automatic find_t find_free(logic [WORD_BITS-1:0] word,
                                      logic [WORD_BITS-1:0] mask);
    find_t res;
    res = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (mask[i] && !word[i]) begin
        res.found = 1'b1;
        res.pos   = BIT_W'(i);
      end
    end
    return res;
  endfunction

endpackage

@@ src/bitmap_handle_allocator.sv @@
// flow: free, query and get pass through a check state to the result, straight to it if out of range;
//   allocate scans the bitmap word by word until a slot is free, then takes its generation; limit 0 skips the scan
// throughput: one request at a time, held up by the bitmap scan
//   that reads one 64-bit occupancy word per cycle from its single read port
// reset: a clearing pass writes every generation to 1 and every bitmap word to 0;
//   no request is taken during it, register writes are taken at once
module bitmap_handle_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  bha_pkg::req_t              in_data_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output bha_pkg::rsp_t              out_data_o,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bha_pkg::CFG_AW-1:0] paddr,
  input  logic [bha_pkg::CFG_DW-1:0] pwdata,
  output logic [bha_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);

  import bha_pkg::*;

  // active slot limit, already capped at the slot count
  logic [CNT_W-1:0]     limit;
  // occupancy bitmap memory: one word of 64 slots per row
  occ_req_t             occ_req;
  logic [WORD_BITS-1:0] occ_rdata;
  // generation memory: one 8-bit counter per slot
  gen_req_t             gen_req;
  logic [GEN_W-1:0]     gen_rdata;

  bha_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  // both memories have registered read data; the sequencer issues the read
  // in the cycle before it needs the word, and handles one request at a time so
  // a write-back always lands before the next read of the same row
  bha_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (occ_req.we),
    .waddr_i (occ_req.waddr),
    .wdata_i (occ_req.wdata),
    .raddr_i (occ_req.raddr),
    .rdata_o (occ_rdata)
  );

  bha_ram #(
    .WIDTH (GEN_W),
    .DEPTH (SLOT_COUNT)
  ) u_gen_ram (
    .clk_i   (clk_i),
    .we_i    (gen_req.we),
    .waddr_i (gen_req.waddr),
    .wdata_i (gen_req.wdata),
    .raddr_i (gen_req.raddr),
    .rdata_o (gen_rdata)
  );

  // sequencer: clearing pass, word-by-word scan for allocate,
  // read-modify-write for free, lookup for query and get,
  // and the output register that holds the result until taken
  bha_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .limit_i     (limit),
    .occ_req_o   (occ_req),
    .occ_rdata_i (occ_rdata),
    .gen_req_o   (gen_req),
    .gen_rdata_i (gen_rdata)
  );

endmodule

@@ src/bha_ram.sv @@
module bha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/bha_cfg.sv @@
module bha_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bha_pkg::CFG_AW-1:0] paddr,
  input  logic [bha_pkg::CFG_DW-1:0] pwdata,
  output logic [bha_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output logic [bha_pkg::CNT_W-1:0]  limit_o
);

  import bha_pkg::*;

  logic [CNT_W-1:0] max_ent_q;
  logic [CNT_W-1:0] max_ent_d;
  logic             hit;

  assign hit = (paddr[CFG_AW-1:2] == REG_MAX_ENTITIES);

  always_comb begin
    max_ent_d = max_ent_q;
    if (psel && penable && pwrite && hit) begin
      max_ent_d = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_ent_q <= MAX_ENT_RESET;
    end else begin
      max_ent_q <= max_ent_d;
    end
  end

  assign prdata  = hit ? CFG_DW'(max_ent_q) : '0;
  assign pready  = 1'b1;
  // limit capped at the slot count
  assign limit_o = (max_ent_q > CNT_W'(SLOT_COUNT)) ? CNT_W'(SLOT_COUNT) : max_ent_q;

endmodule

@@ src/bha_seq.sv @@
module bha_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  bha_pkg::req_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output bha_pkg::rsp_t                out_data_o,
  input  logic [bha_pkg::CNT_W-1:0]    limit_i,
  output bha_pkg::occ_req_t            occ_req_o,
  input  logic [bha_pkg::WORD_BITS-1:0] occ_rdata_i,
  output bha_pkg::gen_req_t            gen_req_o,
  input  logic [bha_pkg::GEN_W-1:0]    gen_rdata_i
);

  import bha_pkg::*;

  `include "assert_macros.svh"

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  clr_q, clr_d;
  logic [CNT_W-1:0]  live_cnt_q, live_cnt_d;
  logic              out_valid_q, out_valid_d;
  op_e               op_q, op_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  limit_q, limit_d;
  logic [WIDX_W-1:0] word_q, word_d;
  rsp_t              res_q, res_d;
  rsp_t              out_q, out_d;

  logic                 accept;
  logic                 out_free;
  logic                 clr_done;
  logic                 in_range;
  logic                 was_live;
  logic                 last_word;
  logic [WIDX_W:0]      word_ext;
  logic [WIDX_W:0]      next_base;
  logic [WORD_BITS-1:0] scan_mask;
  find_t                hit;
  logic [GEN_W-1:0]     gen_next;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || out_ready_i;
  assign clr_done  = (clr_q == IDX_W'(SLOT_COUNT - 1));
  assign in_range  = ({1'b0, in_data_i.slot_index} < limit_i);
  assign was_live  = occ_rdata_i[idx_q[BIT_W-1:0]];
  assign gen_next  = (gen_rdata_i == GEN_WRAP) ? GEN_FIRST : gen_rdata_i + GEN_FIRST;

  // slots at or above the limit count as taken
  assign word_ext  = {1'b0, word_q};
  assign next_base = word_ext + (WIDX_W + 1)'(1);
  assign last_word = ({next_base, BIT_W'(0)} >= limit_q);

  always_comb begin
    if (word_ext < limit_q[CNT_W-1:BIT_W]) begin
      scan_mask = '1;
    end else if (word_ext == limit_q[CNT_W-1:BIT_W]) begin
      scan_mask = (WORD_BITS'(1) << limit_q[BIT_W-1:0]) - WORD_BITS'(1);
    end else begin
      scan_mask = '0;
    end
  end

  assign hit = find_free(occ_rdata_i, scan_mask);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_data_i.op == OP_ALLOC) begin
            state_d = (limit_i == '0) ? ST_RESP : ST_SCAN;
          end else begin
            state_d = in_range ? ST_CHECK : ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        if (hit.found) begin
          state_d = ST_ALLOC;
        end else if (last_word) begin
          state_d = ST_RESP;
        end
      end
      ST_ALLOC: state_d = ST_RESP;
      ST_CHECK: state_d = ST_RESP;
      ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    clr_d       = clr_q;
    live_cnt_d  = live_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    op_d        = op_q;
    idx_d       = idx_q;
    limit_d     = limit_q;
    word_d      = word_q;
    res_d       = res_q;
    out_d       = out_q;
    in_ready_o  = 1'b0;

    occ_req_o.we    = 1'b0;
    occ_req_o.waddr = word_q;
    occ_req_o.wdata = occ_rdata_i;
    occ_req_o.raddr = word_q;
    gen_req_o.we    = 1'b0;
    gen_req_o.waddr = idx_q;
    gen_req_o.wdata = gen_rdata_i;
    gen_req_o.raddr = idx_q;

    case (state_q)
      ST_CLEAR: begin
        occ_req_o.we    = 1'b1;
        occ_req_o.waddr = clr_q[WIDX_W-1:0];
        occ_req_o.wdata = '0;
        gen_req_o.we    = 1'b1;
        gen_req_o.waddr = clr_q;
        gen_req_o.wdata = GEN_FIRST;
        clr_d           = clr_q + IDX_W'(1);
      end
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        occ_req_o.raddr = (in_data_i.op == OP_ALLOC) ? '0
                          : in_data_i.slot_index[IDX_W-1:BIT_W];
        gen_req_o.raddr = in_data_i.slot_index;
        if (accept) begin
          op_d                 = in_data_i.op;
          idx_d                = in_data_i.slot_index;
          limit_d              = limit_i;
          word_d               = '0;
          res_d                = '0;
          if (in_data_i.op == OP_ALLOC) begin
            res_d.status       = STATUS_FULL;
          end else begin
            res_d.handle_index = in_data_i.slot_index;
            res_d.status       = in_range ? STATUS_OK : STATUS_BAD;
          end
        end
      end
      ST_SCAN: begin
        occ_req_o.raddr = word_q + WIDX_W'(1);
        if (hit.found) begin
          occ_req_o.we       = 1'b1;
          occ_req_o.waddr    = word_q;
          occ_req_o.wdata    = occ_rdata_i | (WORD_BITS'(1) << hit.pos);
          gen_req_o.raddr    = {word_q, hit.pos};
          res_d.handle_index = {word_q, hit.pos};
          live_cnt_d         = live_cnt_q + CNT_W'(1);
        end else begin
          word_d = word_q + WIDX_W'(1);
        end
      end
      ST_ALLOC: begin
        res_d.generation = gen_rdata_i;
        res_d.is_live    = 1'b1;
        res_d.status     = STATUS_OK;
      end
      ST_CHECK: begin
        res_d.generation = gen_rdata_i;
        res_d.is_live    = was_live;
        res_d.status     = STATUS_OK;
        case (op_q)
          OP_FREE: begin
            res_d.is_live = 1'b0;
            if (was_live) begin
              res_d.generation = gen_next;
              gen_req_o.we     = 1'b1;
              gen_req_o.waddr  = idx_q;
              gen_req_o.wdata  = gen_next;
              occ_req_o.we     = 1'b1;
              occ_req_o.waddr  = idx_q[IDX_W-1:BIT_W];
              occ_req_o.wdata  = occ_rdata_i & ~(WORD_BITS'(1) << idx_q[BIT_W-1:0]);
              live_cnt_d       = live_cnt_q - CNT_W'(1);
            end else begin
              res_d.status = STATUS_BAD;
            end
          end
          OP_GET: begin
            if (!was_live) res_d.status = STATUS_BAD;
          end
          default: begin
          end
        endcase
      end
      ST_RESP: begin
        if (out_free) begin
          out_d            = res_q;
          out_d.live_total = live_cnt_q;
          out_valid_d      = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      live_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      live_cnt_q  <= live_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    idx_q   <= idx_d;
    limit_q <= limit_d;
    word_q  <= word_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `BHA_ASSERT(a_live_bound, live_cnt_q <= CNT_W'(SLOT_COUNT), "live count above slot count")
  `BHA_ASSERT(a_live_step, (live_cnt_q == $past(live_cnt_q)) || (live_cnt_q == $past(live_cnt_q) + CNT_W'(1)) || (live_cnt_q == $past(live_cnt_q) - CNT_W'(1)), "live count jumped")
  `BHA_ASSERT(a_alloc_live, (state_q == ST_ALLOC) |=> (res_q.is_live && res_q.status == STATUS_OK), "allocation result not live")
  `BHA_ASSERT(a_ok_gen, (state_q == ST_RESP && res_q.status == STATUS_OK) |-> (res_q.generation != '0), "zero generation on success")
  `BHA_ASSERT_ALWAYS(a_clear_empty, (state_q == ST_CLEAR) |-> (live_cnt_q == '0 && !out_valid_q), "activity during clearing pass")

endmodule
